### hdl/frustum_box_cull_test_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef FRUSTUM_BOX_CULL_TEST_UNIT_MACROS_SVH
`define FRUSTUM_BOX_CULL_TEST_UNIT_MACROS_SVH

// The consequent must hold whenever the antecedent holds, outside reset.
`define FBCT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The expression must hold at every clock edge outside reset.
`define FBCT_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

`endif

### hdl/fbct_pkg.sv
package fbct_pkg;

  localparam int NUM_PLANES = 6;
  localparam int COORD_W    = 16;
  localparam int NORM_W     = 14;
  localparam int OFFS_W     = 20;
  localparam int FRAC_SHIFT = 12;
  localparam int PLANE_W    = 3 * NORM_W + OFFS_W;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = NORM_W + COORD_W;
  localparam int OFF_W      = OFFS_W + FRAC_SHIFT;
  localparam int DIST_W     = OFF_W + 3;

  // One plane as it sits in its register; nx occupies the low bits.
  typedef struct packed {
    logic signed [OFFS_W-1:0] d;
    logic signed [NORM_W-1:0] nz;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] max_z;
    logic signed [COORD_W-1:0] max_y;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_z;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] min_x;
  } box_t;

  // What one cell hands to the next.
  typedef struct packed {
    logic valid;
    logic visible;
    box_t box;
  } pipe_t;

endpackage

### hdl/fbct_cell.sv
module fbct_cell
  import fbct_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               plane_we,
  input  logic [PLANE_W-1:0] plane_data,
  input  pipe_t              pipe_i,
  output pipe_t              pipe_o
);

  plane_t plane_r;

  // Stage A: the six axis products, both ends of the box on each axis.
  logic                     a_valid_r;
  logic                     a_vis_r;
  box_t                     a_box_r;
  logic signed [PROD_W-1:0] px_lo_r, px_hi_r, py_lo_r, py_hi_r, pz_lo_r, pz_hi_r;

  // Stage B: distance of the farthest corner along the normal.
  logic                     b_valid_r;
  logic                     b_vis_r;
  box_t                     b_box_r;

  logic signed [PROD_W-1:0] mx, my, mz;
  logic signed [OFF_W-1:0]  off;
  logic signed [DIST_W-1:0] dist_sum;
  logic                     in_front;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (plane_we) begin
      plane_r <= plane_t'(plane_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= pipe_i.valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_vis_r <= pipe_i.visible;
    a_box_r <= pipe_i.box;
    px_lo_r <= PROD_W'(plane_r.nx) * PROD_W'(pipe_i.box.min_x);
    px_hi_r <= PROD_W'(plane_r.nx) * PROD_W'(pipe_i.box.max_x);
    py_lo_r <= PROD_W'(plane_r.ny) * PROD_W'(pipe_i.box.min_y);
    py_hi_r <= PROD_W'(plane_r.ny) * PROD_W'(pipe_i.box.max_y);
    pz_lo_r <= PROD_W'(plane_r.nz) * PROD_W'(pipe_i.box.min_z);
    pz_hi_r <= PROD_W'(plane_r.nz) * PROD_W'(pipe_i.box.max_z);
    b_vis_r <= a_vis_r & in_front;
    b_box_r <= a_box_r;
  end

  // The distance is separable per axis, so some corner lies strictly inside
  // exactly when the sum of the per-axis maxima does. Taking the larger
  // product keeps this exact even when a minimum exceeds its maximum.
  always_comb begin
    mx       = (px_hi_r > px_lo_r) ? px_hi_r : px_lo_r;
    my       = (py_hi_r > py_lo_r) ? py_hi_r : py_lo_r;
    mz       = (pz_hi_r > pz_lo_r) ? pz_hi_r : pz_lo_r;
    off      = {plane_r.d, {FRAC_SHIFT{1'b0}}};
    dist_sum = DIST_W'(mx) + DIST_W'(my) + DIST_W'(mz) + DIST_W'(off);
    in_front = (dist_sum > 0);
  end

  assign pipe_o.valid   = b_valid_r;
  assign pipe_o.visible = b_vis_r;
  assign pipe_o.box     = b_box_r;

endmodule

### hdl/frustum_box_cull_test_unit.sv
// Six-plane box cull: one box accepted every cycle, busy is always low.
// Each box passes through two register stages (products, then distance) per cell,
// in each of the six cells in turn, and out_valid then marks its result.
// Throughput is one box per cycle; results cannot be stalled.
// Synchronous reset clears all planes to zero (every box culled) and empties
// the pipeline.
module frustum_box_cull_test_unit
  import fbct_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_W-1:0]  in_box_min_x,
  input  logic signed [COORD_W-1:0]  in_box_min_y,
  input  logic signed [COORD_W-1:0]  in_box_min_z,
  input  logic signed [COORD_W-1:0]  in_box_max_x,
  input  logic signed [COORD_W-1:0]  in_box_max_y,
  input  logic signed [COORD_W-1:0]  in_box_max_z,
  output logic                       out_valid,
  output logic                       out_visible,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [PLANE_W-1:0]         cfg_data
);

  pipe_t chain [NUM_PLANES+1];

  assign busy = 1'b0;

  assign chain[0].valid     = start & ~busy;
  assign chain[0].visible   = 1'b1;
  assign chain[0].box.min_x = in_box_min_x;
  assign chain[0].box.min_y = in_box_min_y;
  assign chain[0].box.min_z = in_box_min_z;
  assign chain[0].box.max_x = in_box_max_x;
  assign chain[0].box.max_y = in_box_max_y;
  assign chain[0].box.max_z = in_box_max_z;

  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_cell
    fbct_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .plane_we   (cfg_we && (cfg_index == CFG_IDX_W'(g))),
      .plane_data (cfg_data),
      .pipe_i     (chain[g]),
      .pipe_o     (chain[g+1])
    );
  end

  assign out_valid   = chain[NUM_PLANES].valid;
  assign out_visible = chain[NUM_PLANES].visible;

endmodule

### hdl/fbct_checker.sv
`include "frustum_box_cull_test_unit_macros.svh"

module fbct_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  localparam int LATENCY = 12;

  logic accept;

  assign accept = start && !busy;

  `FBCT_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy)
  `FBCT_ASSERT_IMPLIES(a_result_follows, clk, rst_n, accept, ##LATENCY out_valid)
  `FBCT_ASSERT_IMPLIES(a_no_spurious_result, clk, rst_n, out_valid, $past(accept, LATENCY))

endmodule

bind frustum_box_cull_test_unit fbct_checker u_fbct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);
